@@ design/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg: shared constants, tables and round functions for the aes-128 engine
// byte i of a 128-bit value sits at bits [127-8i -: 8]
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int Rounds = 10;
	localparam int KeyEntries = Rounds + 1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// register indexes
	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	localparam logic MODE_DECRYPT = 1'b1;

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// forward: sub bytes + shift rows
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
		sub_shift = t;
	endfunction

	// inverse shift rows + inverse sub bytes
	function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[s[127-8*(4*c+r) -: 8]];
		inv_sub_shift = t;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r] = s[127-8*(4*c+r) -: 8];
				x[r] = xtime(a[r]);
			end
			for (int r = 0; r < 4; r++)
				t[127-8*(4*c+r) -: 8] = x[r] ^ x[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
		end
		mix = t;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9, mb, md, me;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r] = s[127-8*(4*c+r) -: 8];
				x2[r] = xtime(a[r]);
				x4[r] = xtime(x2[r]);
				x8[r] = xtime(x4[r]);
			end
			for (int r = 0; r < 4; r++) begin
				me = x8[r] ^ x4[r] ^ x2[r];
				mb = x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4];
				md = x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4];
				m9 = x8[(r+3)%4] ^ a[(r+3)%4];
				t[127-8*(4*c+r) -: 8] = me ^ mb ^ md ^ m9;
			end
		end
		inv_mix = t;
	endfunction

	// one step of the key schedule, rcon supplied
	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		key_step = {w0, w1, w2, w3};
	endfunction

endpackage

@@ design/aes128_block_engine.sv @@
// ----------------------------------------------------------------------------
// aes128_block_engine: aes-128 ecb block cipher, one round per cycle
// key loaded over apb, blocks in and out over streams
// ----------------------------------------------------------------------------
// channel   direction  content
// s_axis    in         tuser = mode, tdata = {block_low, block_high}
// m_axis    out        tdata = {result_low, result_high}
// apb       in/out     key_high at 0x0, key_low at 0x8
//
// a block is loaded with the first round key, goes through ten rounds in the
// shared round unit, then is handed over to the output register
// a key write loads round key 0 at its access edge, the other ten follow
// one per cycle, and blocks wait until the last one is in
// after reset the zero key expands before the first block is taken
// s_axis_tready is low while a block runs, keys expand or the result waits
// ----------------------------------------------------------------------------
module aes128_block_engine (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
	input  logic         s_axis_tuser,   // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // result_high [63:0], result_low [127:64]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROUND = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

	localparam logic [3:0] REG_HI_ADDR = {aes_pkg::REG_KEY_HIGH, 3'b000};
	localparam logic [3:0] REG_LO_ADDR = {aes_pkg::REG_KEY_LOW, 3'b000};

	state_t       state_q;
	logic [63:0]  key_high_q, key_low_q;
	logic         ks_busy;
	logic [3:0]   rd_idx;
	logic [127:0] rd_key;
	logic [127:0] st_q;
	logic         mode_q;
	logic [3:0]   rnd_q;
	logic [127:0] out_q;
	logic         out_vld_q;
	logic [127:0] blk_in;
	logic [127:0] enc_mid, dec_mid, rnd_out;
	logic         last;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (psel & penable & pwrite) begin
			if (paddr == REG_HI_ADDR)
				key_high_q <= pwdata;
			else if (paddr == REG_LO_ADDR)
				key_low_q <= pwdata;
		end
	end

	logic key_start;
	assign key_start = psel & penable & pwrite & ((paddr == REG_HI_ADDR) | (paddr == REG_LO_ADDR));

	always_comb begin
		case (paddr)
			REG_HI_ADDR: prdata = key_high_q;
			REG_LO_ADDR: prdata = key_low_q;
			default:     prdata = '0;
		endcase
	end

	// expansion sees the key with the new half merged in
	logic [127:0] new_key;
	assign new_key = {(paddr == REG_HI_ADDR) ? pwdata : key_high_q,
		(paddr == REG_LO_ADDR) ? pwdata : key_low_q};

	aes_key_sched u_ks (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (key_start),
		.key    (new_key),
		.rd_idx (rd_idx),
		.rd_key (rd_key),
		.busy   (ks_busy)
	);

	assign blk_in = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign s_axis_tready = (state_q == ST_IDLE) & ~ks_busy & ~out_vld_q;

	// round key index: encrypt counts up, decrypt counts down
	always_comb begin
		if (state_q == ST_IDLE)
			rd_idx = (s_axis_tuser == aes_pkg::MODE_DECRYPT) ? 4'(aes_pkg::Rounds) : 4'd0;
		else
			rd_idx = (mode_q == aes_pkg::MODE_DECRYPT) ? 4'(aes_pkg::Rounds) - rnd_q : rnd_q;
	end

	// shared round unit
	assign last = (rnd_q == 4'(aes_pkg::Rounds));
	assign enc_mid = last ? aes_pkg::sub_shift(st_q) : aes_pkg::mix(aes_pkg::sub_shift(st_q));
	assign dec_mid = aes_pkg::inv_sub_shift(st_q) ^ rd_key;
	always_comb begin
		if (mode_q == aes_pkg::MODE_DECRYPT)
			rnd_out = last ? dec_mid : aes_pkg::inv_mix(dec_mid);
		else
			rnd_out = enc_mid ^ rd_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rnd_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (m_axis_tvalid & m_axis_tready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid & s_axis_tready) begin
						state_q <= ST_ROUND;
						rnd_q   <= 4'd1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 4'd1;
					if (last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					out_vld_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
			st_q   <= blk_in ^ rd_key;
			mode_q <= s_axis_tuser;
		end else if (state_q == ST_ROUND)
			st_q <= rnd_out;
		if (state_q == ST_DONE)
			out_q <= st_q;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

endmodule

@@ design/aes_key_sched.sv @@
// ----------------------------------------------------------------------------
// aes_key_sched: round key expansion into a small register file
// one round key per cycle; start re-runs the expansion from the given key
// ----------------------------------------------------------------------------
module aes_key_sched (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	input  logic [3:0]   rd_idx,
	output logic [127:0] rd_key,
	output logic         busy
);

	logic [127:0] rk_q [aes_pkg::KeyEntries];
	logic [127:0] cur_q;
	logic [7:0]   rcon_q;
	logic [3:0]   idx_q;
	logic         busy_q;
	logic [127:0] nxt;

	assign nxt = aes_pkg::key_step(cur_q, rcon_q);
	assign busy = busy_q;
	assign rd_key = rk_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd1;
			rcon_q <= 8'h01;
			cur_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd1;
			rcon_q <= 8'h01;
			cur_q  <= key;
		end else if (busy_q) begin
			cur_q  <= nxt;
			rcon_q <= aes_pkg::xtime(rcon_q);
			idx_q  <= idx_q + 4'd1;
			if (idx_q == 4'(aes_pkg::Rounds))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			rk_q[0] <= key;
		else if (busy_q) begin
			if (idx_q == 4'd1)
				rk_q[0] <= cur_q;
			rk_q[idx_q] <= nxt;
		end
	end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: aes-128 ecb block engine testbench
// loads keys over apb, streams blocks in both modes, and checks each result
// against a behavioral aes-128 cipher kept alongside the design
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// expected results of accepted blocks, oldest first
class cipher_scoreboard;
	logic [127:0] pending_results [$];
	int mismatches;

	function void note_block(logic [127:0] result);
		pending_results.push_back(result);
	endfunction

	function void check_result(logic [63:0] res_high, logic [63:0] res_low);
		logic [127:0] want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h_%h", res_high, res_low);
			return;
		end
		want = pending_results.pop_front();
		if (want[127:64] !== res_high || want[63:0] !== res_low) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %h_%h, got %h_%h",
					want[127:64], want[63:0], res_high, res_low);
		end
	endfunction
endclass

module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // block_high [63:0], block_low [127:64]
	logic         s_axis_tuser;   // mode
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;   // result_high [63:0], result_low [127:64]
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;

	aes128_block_engine u_top (.*);

	// own copy of the key and its schedule
	logic [63:0]  key_hi_copy;
	logic [63:0]  key_lo_copy;
	logic [127:0] sched [11];

	cipher_scoreboard board;
	int  idle_cycles;
	bit  rx_hold;       // receiver holds off for a long stretch
	bit  done;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// ------------------------------------------------------------------
	// cipher arithmetic, written byte by byte in bus order
	// ------------------------------------------------------------------
	function automatic logic [7:0] gf_double(logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = gf_double(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] byte_of(logic [127:0] v, int i);
		return v[127-8*i -: 8];
	endfunction

	function automatic logic [7:0] sbox_inverse(logic [7:0] v);
		for (int i = 0; i < 256; i++)
			if (aes_pkg::SBOX[i] == v)
				return i[7:0];
		return 8'h00;
	endfunction

	function automatic void expand_schedule();
		logic [7:0] w [176];
		logic [7:0] t [4];
		logic [7:0] f;
		logic [7:0] rc;
		logic [127:0] k;
		k = {key_hi_copy, key_lo_copy};
		rc = 8'h01;
		for (int i = 0; i < 16; i++)
			w[i] = byte_of(k, i);
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++)
				t[j] = w[i-4+j];
			if (i % 16 == 0) begin
				f = t[0];
				t[0] = aes_pkg::SBOX[t[1]] ^ rc;
				t[1] = aes_pkg::SBOX[t[2]];
				t[2] = aes_pkg::SBOX[t[3]];
				t[3] = aes_pkg::SBOX[f];
				rc = gf_double(rc);
			end
			for (int j = 0; j < 4; j++)
				w[i+j] = w[i-16+j] ^ t[j];
		end
		for (int r = 0; r < 11; r++)
			for (int i = 0; i < 16; i++)
				sched[r][127-8*i -: 8] = w[16*r+i];
	endfunction

	function automatic logic [127:0] mix_state(logic [127:0] s, bit inverse);
		logic [7:0] m [4];
		logic [7:0] a [4];
		logic [127:0] o;
		if (inverse) begin
			m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
		end else begin
			m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++)
				a[r] = byte_of(s, 4*c+r);
			for (int r = 0; r < 4; r++)
				o[127-8*(4*c+r) -: 8] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)%4], m[1])
					^ gf_mul(a[(r+2)%4], m[2]) ^ gf_mul(a[(r+3)%4], m[3]);
		end
		return o;
	endfunction

	function automatic logic [127:0] cipher_block(logic [127:0] s, bit decrypt);
		logic [127:0] t;
		if (!decrypt) begin
			s ^= sched[0];
			for (int r = 1; r <= 10; r++) begin
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						t[127-8*(4*c+w) -: 8] = aes_pkg::SBOX[byte_of(s, 4*((c+w)%4)+w)];
				s = (r < 10) ? mix_state(t, 1'b0) : t;
				s ^= sched[r];
			end
		end else begin
			s ^= sched[10];
			for (int r = 9; r >= 0; r--) begin
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						t[127-8*(4*((c+w)%4)+w) -: 8] = sbox_inverse(byte_of(s, 4*c+w));
				s = t ^ sched[r];
				if (r > 0)
					s = mix_state(s, 1'b1);
			end
		end
		return s;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic write_key_reg(logic idx, logic [63:0] value);
		// setup then access phase; pready is always high
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= idx ? 4'h8 : 4'h0; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == aes_pkg::REG_KEY_HIGH)
			key_hi_copy = value;
		else
			key_lo_copy = value;
		expand_schedule();
		// let the key expansion run before the next block
		repeat (15) @(posedge clk);
	endtask

	// offer one block, wait for the transfer, then an optional gap
	task automatic send_block(bit decrypt, logic [63:0] hi, logic [63:0] lo, int gap);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= decrypt;
		s_axis_tdata  <= {lo, hi};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_block(cipher_block({hi, lo}, decrypt));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random block, sometimes with all-zero or all-one halves
	task automatic send_random(int max_gap);
		logic [63:0] hi, lo;
		hi = rand64();
		lo = rand64();
		case ($urandom_range(0, 9))
			0: hi = '0;
			1: lo = '1;
			default: ;
		endcase
		send_block(1'($urandom_range(0, 1)), hi, lo,
			($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap));
	endtask

	// ------------------------------------------------------------------
	// receiver: random stall per result, or a long hold on request
	// ------------------------------------------------------------------
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 15);
			if (stall > 0 || rx_hold) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (rx_hold)
					@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			board.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64]);
		end
	end

	// watchdog on cycles without any transfer or key write
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| psel || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("aes128_block_engine verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [63:0] key_pairs [4][2];
		board = new();
		idle_cycles = 0;
		rx_hold = 1'b0;
		done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		key_hi_copy = '0;
		key_lo_copy = '0;
		expand_schedule();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// zero key expands after reset
		repeat (20) @(posedge clk);

		// directed: reset key, extremes of the block, both modes
		send_block(1'b0, '0, '0, 0);
		send_block(1'b1, '0, '0, 0);
		send_block(1'b0, '1, '1, 1);
		send_block(1'b1, '1, '1, 0);
		send_block(1'b0, 64'h8000_0000_0000_0001, 64'h0000_0000_0000_0000, 0);
		end_burst();
		wait_drained();

		// known vector from the standard appendix
		write_key_reg(aes_pkg::REG_KEY_HIGH, 64'h0001_0203_0405_0607);
		write_key_reg(aes_pkg::REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
		send_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 0);
		send_block(1'b1, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a, 0);
		send_block(1'b0, '1, '0, 2);
		send_block(1'b1, '0, '1, 0);
		end_burst();
		wait_drained();

		// all-ones key, then its low half set to zero
		write_key_reg(aes_pkg::REG_KEY_HIGH, '1);
		write_key_reg(aes_pkg::REG_KEY_LOW, '1);
		send_block(1'b0, '0, '0, 0);
		send_block(1'b1, '1, '1, 0);
		send_block(1'b0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0);
		end_burst();
		wait_drained();
		write_key_reg(aes_pkg::REG_KEY_LOW, '0);
		send_block(1'b1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 0);
		send_block(1'b0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 0);
		end_burst();
		wait_drained();

		// random phases over several keys, the last one back to zero
		key_pairs[0] = '{rand64(), rand64()};
		key_pairs[1] = '{rand64(), '1};
		key_pairs[2] = '{rand64(), rand64()};
		key_pairs[3] = '{'0, '0};
		for (int k = 0; k < 4; k++) begin
			write_key_reg(aes_pkg::REG_KEY_HIGH, key_pairs[k][0]);
			write_key_reg(aes_pkg::REG_KEY_LOW, key_pairs[k][1]);
			if (k == 1) begin
				// long receiver hold while blocks keep coming
				rx_hold = 1'b1;
				fork
					begin
						repeat (300) @(posedge clk);
						rx_hold = 1'b0;
					end
				join_none
			end
			for (int i = 0; i < 105; i++) begin
				send_random(15);
				if (i % 40 == 39) begin
					// pause until every pending result is back
					end_burst();
					wait_drained();
				end
			end
			end_burst();
			wait_drained();
		end

		done = 1'b1;
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("aes128_block_engine verification clean");
		else
			$display("aes128_block_engine verification failed");
		$finish;
	end

endmodule
